@@ sv/best_fit_lifetime_offset_allocator_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the best-fit lifetime offset allocator
// Shared wrappers for the concurrent checks in the top level.
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_LIFETIME_OFFSET_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_LIFETIME_OFFSET_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BFLA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BFLA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/bfla_pkg.sv @@
// ----------------------------------------------------------------------------
// bfla_pkg
// Types and constants shared by the allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bfla_pkg;

  localparam int MAX_SLOTS = 64;
  localparam int IDX_W     = $clog2(MAX_SLOTS);
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

  localparam int OFF_W     = 48;
  localparam int BYTES_W   = 33;
  localparam int FREE_W    = 17;
  localparam int SIZE_W    = 32;
  localparam int LIVE_W    = 16;
  localparam int ALIGN_W   = 4;
  localparam int MASK_W    = 16;

  localparam logic [ALIGN_W-1:0] ALIGN_RESET = 4'd4;

  typedef struct packed {
    logic [OFF_W-1:0]   base;
    logic [BYTES_W-1:0] bytes;
    logic [FREE_W-1:0]  free_from;
  } slot_t;

  // compare unit control
  typedef struct packed {
    logic clear;   // drop the current best at the start of an item
    logic valid;   // read data holds a live slot to compare
  } scan_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PLACE,
    S_GROW,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

@@ sv/bfla_slot_ram.sv @@
// ----------------------------------------------------------------------------
// bfla_slot_ram
// Slot table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfla_slot_ram
  import bfla_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire slot_t            wr_data,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output slot_t                 rd_data
);

  slot_t mem [MAX_SLOTS];
  slot_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ sv/bfla_scan.sv @@
// ----------------------------------------------------------------------------
// bfla_scan
// Best-fit compare unit, fed one slot per cycle; keeps the best so far.
// ----------------------------------------------------------------------------
`default_nettype none

module bfla_scan
  import bfla_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire scan_ctl_t          ctl,
  input  wire slot_t              entry,
  input  wire logic [IDX_W-1:0]   entry_idx,
  input  wire logic [LIVE_W-1:0]  first_use,
  input  wire logic [BYTES_W-1:0] needed,
  output logic                    found,
  output slot_t                   best,
  output logic [IDX_W-1:0]        best_idx
);

  logic             found_r, found_nxt;
  slot_t            best_r, best_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic             fits;

  // strict less keeps the lowest index on equal sizes (ascending scan)
  assign fits = (entry.free_from <= {1'b0, first_use}) &&
                (entry.bytes >= needed) &&
                (!found_r || (entry.bytes < best_r.bytes));

  always_comb begin
    found_nxt    = found_r;
    best_nxt     = best_r;
    best_idx_nxt = best_idx_r;
    if (ctl.clear) begin
      found_nxt = 1'b0;
    end else if (ctl.valid && fits) begin
      found_nxt    = 1'b1;
      best_nxt     = entry;
      best_idx_nxt = entry_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
  end

  assign found    = found_r;
  assign best     = best_r;
  assign best_idx = best_idx_r;

endmodule

`default_nettype wire

@@ sv/best_fit_lifetime_offset_allocator.sv @@
// ----------------------------------------------------------------------------
// best_fit_lifetime_offset_allocator
// Assigns arena offsets to buffers, reusing the smallest freed slot that fits.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata / data                     | tuser
//  --------+-----------+----------------------------------+-------------------
//  in_     | slave     | first_use, last_use, nbytes      | new_plan
//  out_    | master    | offset, arena_top                | placed, reused, full
//  cfg_    | slave     | align_log2                       | -
//
//  Each item of nonzero size is either placed in a freed slot or at the arena
//  top, after a best-fit scan that reads the slot table once per recorded
//  slot through a single registered read port into one shared compare unit;
//  a zero-size item skips the scan.
//  Reset (rst_n low, synchronous) empties the slot table, clears the arena
//  top and sets the alignment to 16 bytes. A finished result waits in the
//  output register; the next transaction is taken meanwhile and holds in the
//  final state only if the previous result is still unread.
//
`default_nettype none
`include "best_fit_lifetime_offset_allocator_defines.svh"

module best_fit_lifetime_offset_allocator
  import bfla_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input buffers
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [63:0]  in_tdata,   // first_use[15:0], last_use[31:16], nbytes[63:32]
  input  wire logic [0:0]   in_tuser,   // new_plan[0]
  // results
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [95:0]       out_tdata,  // offset[47:0], arena_top[95:48]
  output logic [2:0]        out_tuser,  // placed[0], reused[1], table_full[2]
  // alignment register
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [3:0]   cfg_data    // align_log2[3:0]
);

  // saturate a 49-bit sum to 48 bits
  function automatic logic [OFF_W-1:0] sat48(input logic [OFF_W:0] v);
    sat48 = v[OFF_W] ? {OFF_W{1'b1}} : v[OFF_W-1:0];
  endfunction

  // --- state -----------------------------------------------------------------
  state_t               state_r, state_nxt;
  logic [ALIGN_W-1:0]   align_r, align_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [OFF_W-1:0]     top_r, top_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic                 pend_r, pend_nxt;
  logic [IDX_W-1:0]     pend_idx_r, pend_idx_nxt;

  // per-item working registers
  logic [LIVE_W-1:0]    start_r, start_nxt;
  logic [FREE_W-1:0]    free_r, free_nxt;
  logic [BYTES_W-1:0]   needed_r, needed_nxt;
  logic                 placed_r, placed_nxt;
  logic                 full_r, full_nxt;
  logic [OFF_W-1:0]     off_r, off_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [95:0]          out_data_r, out_data_nxt;
  logic [2:0]           out_user_r, out_user_nxt;

  // --- datapath helpers ------------------------------------------------------
  logic                 in_acc, out_acc;
  logic [MASK_W-1:0]    mask;
  logic [SIZE_W-1:0]    in_size;
  logic [OFF_W:0]       top_aligned;
  logic [OFF_W:0]       top_grown;
  logic                 issue;

  scan_ctl_t            scan_ctl;
  slot_t                rd_data, wr_data, best;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr, best_idx;
  logic                 found;

  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_valid_r && out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_size   = in_tdata[63:32];

  assign mask        = (MASK_W'(1) << align_r) - MASK_W'(1);
  assign top_aligned = ({1'b0, top_r} + {{(OFF_W + 1 - MASK_W){1'b0}}, mask}) &
                       ~{{(OFF_W + 1 - MASK_W){1'b0}}, mask};
  assign top_grown   = {1'b0, off_r} + {{(OFF_W + 1 - BYTES_W){1'b0}}, needed_r};

  // a read is issued while unscanned recorded slots remain
  assign issue = (state_r == S_SCAN) && (idx_r < count_r);

  bfla_slot_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (issue),
    .rd_addr (idx_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  assign scan_ctl.clear = in_acc;
  assign scan_ctl.valid = pend_r;

  bfla_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (scan_ctl),
    .entry      (rd_data),
    .entry_idx  (pend_idx_r),
    .first_use  (start_r),
    .needed     (needed_r),
    .found      (found),
    .best       (best),
    .best_idx   (best_idx)
  );

  // --- sequencer -------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    align_nxt     = align_r;
    count_nxt     = count_r;
    top_nxt       = top_r;
    idx_nxt       = idx_r;
    pend_nxt      = issue;
    pend_idx_nxt  = idx_r[IDX_W-1:0];
    start_nxt     = start_r;
    free_nxt      = free_r;
    needed_nxt    = needed_r;
    placed_nxt    = placed_r;
    full_nxt      = full_r;
    off_nxt       = off_r;
    out_valid_nxt = out_acc ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    wr_en         = 1'b0;
    wr_addr       = count_r[IDX_W-1:0];
    wr_data       = '{base: off_r, bytes: needed_r, free_from: free_r};

    if (cfg_valid && cfg_ready) begin
      align_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          start_nxt  = in_tdata[15:0];
          free_nxt   = {1'b0, in_tdata[31:16]} + FREE_W'(1);
          needed_nxt = ({1'b0, in_size} + {{(BYTES_W - MASK_W){1'b0}}, mask}) &
                       ~{{(BYTES_W - MASK_W){1'b0}}, mask};
          placed_nxt = (in_size != '0);
          full_nxt   = 1'b0;
          off_nxt    = '0;
          idx_nxt    = '0;
          if (in_tuser[0]) begin
            count_nxt = '0;
            top_nxt   = '0;
          end
          state_nxt = (in_size != '0) ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (issue) begin
          idx_nxt = idx_r + CNT_W'(1);
        end else if (!pend_r) begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        if (found) begin
          // reuse: slot keeps base and size, only its free point moves
          off_nxt   = best.base;
          wr_en     = 1'b1;
          wr_addr   = best_idx;
          wr_data   = '{base: best.base, bytes: best.bytes, free_from: free_r};
          state_nxt = S_DONE;
        end else begin
          off_nxt   = sat48(top_aligned);
          state_nxt = S_GROW;
        end
      end
      S_GROW: begin
        top_nxt = sat48(top_grown);
        if (count_r < CNT_W'(MAX_SLOTS)) begin
          wr_en     = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end else begin
          full_nxt = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {top_r, off_r};
          out_user_nxt  = {full_r, found && placed_r, placed_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      align_r     <= ALIGN_RESET;
      count_r     <= '0;
      top_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      align_r     <= align_nxt;
      count_r     <= count_nxt;
      top_r       <= top_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    start_r    <= start_nxt;
    free_r     <= free_nxt;
    needed_r   <= needed_nxt;
    placed_r   <= placed_nxt;
    full_r     <= full_nxt;
    off_r      <= off_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // --- checks ----------------------------------------------------------------
  logic count_ok;
  logic place_hit;
  logic reuse_in_table;
  logic flags_raised;
  logic flags_ok;

  assign count_ok       = (count_r <= CNT_W'(MAX_SLOTS));
  assign place_hit      = (state_r == S_PLACE) && found;
  assign reuse_in_table = ({1'b0, best_idx} < count_r);
  assign flags_raised   = out_valid_r && (out_user_r[1] || out_user_r[2]);
  assign flags_ok       = out_user_r[0] && !(out_user_r[1] && out_user_r[2]);

  `BFLA_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_ok, "slot count beyond table")
  `BFLA_ASSERT_NOW(a_reuse_recorded, clk, rst_n, place_hit, reuse_in_table, "reused slot not recorded")
  `BFLA_ASSERT_NOW(a_flags_consistent, clk, rst_n, flags_raised, flags_ok, "result flags inconsistent")
  `BFLA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_acc, !in_tready, "second transaction taken")

endmodule

`default_nettype wire
